// ----- design/modular_exponentiation_core_assert.svh -----
// Assertion macros shared by the modular exponentiation checker.
`ifndef MODULAR_EXPONENTIATION_CORE_ASSERT_SVH
`define MODULAR_EXPONENTIATION_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MEXP_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modular exponentiation check failed");

// The consequent must hold in the cycle after the antecedent.
`define MEXP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modular exponentiation check failed");

`endif

// ----- design/mexp_pkg.sv -----
// Shared types and constants of the modular exponentiation core.
package mexp_pkg;

    localparam int FIELD_WIDTH = 63;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

// ----- design/mexp_mulmod.sv -----
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
module mexp_mulmod #(
    parameter int W = 63
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [W-1:0]          a,
    input  logic [W-1:0]          b,
    input  logic [W-1:0]          m,
    output logic [W-1:0]          result,
    output mexp_pkg::mm_status_t  status
);

    localparam int CW = $clog2(W);

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  b_reg;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  m_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W:0] dbl;
    logic [W:0] mw;
    logic [W:0] half;
    logic [W:0] sum;
    logic [W:0] red;

    // Double the accumulator and fold it back below m, then add a when the
    // current multiplier bit is set and fold again.
    always_comb
    begin
        mw   = {1'b0, m_reg};
        dbl  = {acc_reg, 1'b0};
        half = (dbl >= mw) ? (dbl - mw) : dbl;
        sum  = half + (b_reg[W-1] ? {1'b0, a_reg} : {(W+1){1'b0}});
        red  = (sum >= mw) ? (sum - mw) : sum;
        acc_next = red[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            m_reg   <= m;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[W-2:0], 1'b0};
        end
    end

    assign result      = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ----- design/modular_exponentiation_core.sv -----
// One square-and-multiply step runs per exponent bit, up to the top set bit of the exponent.
// A zero exponent or a zero modulus skips the multipliers and goes straight to the result.
// One request in flight; the next is accepted once the result has been set.
// The square and the conditional multiply run side by side on two bit-serial multipliers.
// The result register frees the input while a result waits.
// rst_n clears the controller and the result valid flag asynchronously.
module modular_exponentiation_core #(
    parameter int OPERAND_WIDTH = 63
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [mexp_pkg::FIELD_WIDTH-1:0] base,
    input  logic [mexp_pkg::FIELD_WIDTH-1:0] exponent,
    input  logic [mexp_pkg::FIELD_WIDTH-1:0] modulus,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [mexp_pkg::FIELD_WIDTH-1:0] power
);

    localparam int W  = OPERAND_WIDTH;
    localparam int FW = mexp_pkg::FIELD_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_REDUCE,
        S_STEP,
        S_MULT,
        S_FINISH
    } state_t;

    state_t         state_reg, state_next;
    logic [W-1:0]   base_reg, base_next;
    logic [W-1:0]   exp_reg, exp_next;
    logic [W-1:0]   mod_reg, mod_next;
    logic [W-1:0]   acc_reg, acc_next;
    logic [FW-1:0]  power_reg, power_next;
    logic           res_valid_reg, res_valid_next;

    logic                 start0, start1;
    logic [W-1:0]         u0_a;
    logic [W-1:0]         one_mod;
    logic [W-1:0]         res0, res1;
    mexp_pkg::mm_status_t st0, st1;

    // One reduced modulo the modulus: zero when the modulus is one.
    assign one_mod = W'(mod_reg != W'(1));
    assign u0_a    = (state_reg == S_LOAD) ? one_mod : acc_reg;
    assign start0  = (state_reg == S_LOAD) || (state_reg == S_STEP);
    assign start1  = (state_reg == S_STEP);

    // Unit 0 reduces the base, then forms acc * base; unit 1 squares the base.
    mexp_mulmod #(.W(W)) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start0),
        .a      (u0_a),
        .b      (base_reg),
        .m      (mod_reg),
        .result (res0),
        .status (st0)
    );

    mexp_mulmod #(.W(W)) u_sqr (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start1),
        .a      (base_reg),
        .b      (base_reg),
        .m      (mod_reg),
        .result (res1),
        .status (st1)
    );

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        mod_next       = mod_reg;
        acc_next       = acc_reg;
        power_next     = power_reg;
        res_valid_next = res_valid_reg;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    base_next = base[W-1:0];
                    exp_next  = exponent[W-1:0];
                    mod_next  = modulus[W-1:0];
                    if (exponent[W-1:0] == '0)
                    begin
                        acc_next   = W'(1);
                        state_next = S_FINISH;
                    end
                    else if (modulus[W-1:0] == '0)
                    begin
                        acc_next   = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                state_next = S_REDUCE;
            end
            S_REDUCE:
            begin
                if (st0.done)
                begin
                    base_next  = res0;
                    acc_next   = one_mod;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                state_next = S_MULT;
            end
            S_MULT:
            begin
                if (st0.done && !st1.busy)
                begin
                    if (exp_reg[0])
                    begin
                        acc_next = res0;
                    end
                    base_next  = res1;
                    exp_next   = exp_reg >> 1;
                    state_next = (exp_reg[W-1:1] == '0) ? S_FINISH : S_STEP;
                end
            end
            S_FINISH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    power_next     = FW'(acc_reg);
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            base_reg      <= '0;
            exp_reg       <= '0;
            mod_reg       <= '0;
            acc_reg       <= '0;
            power_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            base_reg      <= base_next;
            exp_reg       <= exp_next;
            mod_reg       <= mod_next;
            acc_reg       <= acc_next;
            power_reg     <= power_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign power     = power_reg;

endmodule

// ----- design/mexp_checker.sv -----
// Port-level checker for the modular exponentiation core and its bind.
`include "modular_exponentiation_core_assert.svh"

module mexp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_stall,
    input logic                             res_valid,
    input logic                             res_stall,
    input logic [mexp_pkg::FIELD_WIDTH-1:0] power
);

    `MEXP_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid)
    `MEXP_ASSERT_NEXT(a_power_hold, res_valid && res_stall, $stable(power))
    // A request in flight keeps the input side closed.
    `MEXP_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)
    // A result only appears after the block was working on a request.
    `MEXP_ASSERT_NOW(a_res_from_work, $rose(res_valid), $past(req_stall))

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (.*);

// ----- tb/sv/modular_exponentiation_core_tb.sv -----
// Self-checking testbench for the modular exponentiation core, with a scoreboard and random idling.
`timescale 1ns / 1ps

module modular_exponentiation_core_tb;

    localparam int FW = mexp_pkg::FIELD_WIDTH;
    localparam logic [FW-1:0] ALL_ONES = '1;
    localparam logic [FW-1:0] MERSENNE_61 = {2'b00, {61{1'b1}}};
    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_CYCLES = 10;

    // Predicts each power from the accepted request and checks results in order.
    class power_scoreboard;
        logic [FW-1:0] expected_power_q[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        // Product at double width, then reduced.
        function logic [FW-1:0] mul_mod(logic [FW-1:0] a, logic [FW-1:0] b,
                                        logic [FW-1:0] m);
            logic [2*FW-1:0] wide;
            wide = {{FW{1'b0}}, a} * {{FW{1'b0}}, b};
            wide = wide % {{FW{1'b0}}, m};
            return wide[FW-1:0];
        endfunction

        function logic [FW-1:0] mod_pow(logic [FW-1:0] b, logic [FW-1:0] e,
                                        logic [FW-1:0] m);
            logic [FW-1:0] acc;
            logic [FW-1:0] sq;
            logic [FW-1:0] rest;
            // A zero exponent gives 1 even for a modulus of one or zero.
            if (e == '0)
                return FW'(1);
            if (m == '0)
                return '0;
            acc = (m == FW'(1)) ? '0 : FW'(1);
            sq = b % m;
            rest = e;
            while (rest != '0)
            begin
                if (rest[0])
                    acc = mul_mod(acc, sq, m);
                sq = mul_mod(sq, sq, m);
                rest = rest >> 1;
            end
            return acc;
        endfunction

        function void note_request(logic [FW-1:0] b, logic [FW-1:0] e, logic [FW-1:0] m);
            expected_power_q.insert(expected_power_q.size(), mod_pow(b, e, m));
        endfunction

        function void check_power(logic [FW-1:0] actual);
            logic [FW-1:0] want;
            if (expected_power_q.size() == 0)
            begin
                $error("power: no request outstanding, actual %0h", actual);
                errors++;
            end
            else
            begin
                want = expected_power_q.pop_front();
                if (actual !== want)
                begin
                    $error("power: expected %0h, actual %0h", want, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_power_q.size();
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    logic [FW-1:0] base;
    logic [FW-1:0] exponent;
    logic [FW-1:0] modulus;
    logic          res_valid;
    logic          res_stall;
    logic [FW-1:0] power;

    power_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    bit long_hold;
    int quiet_cycles;

    modular_exponentiation_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .base      (base),
        .exponent  (exponent),
        .modulus   (modulus),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .power     (power)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side: random stalls, or one long hold-off counted here.
    initial
    begin
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Handshake monitor and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(base, exponent, modulus);
            if (res_valid && !res_stall)
                sb.check_power(power);
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic logic [FW-1:0] random_bits(int w);
        logic [FW-1:0] v;
        v = FW'({$urandom, $urandom});
        if (w <= 0)
            return '0;
        if (w >= FW)
            return v;
        return v & ((FW'(1) << w) - FW'(1));
    endfunction

    // Called right after a rising edge; returns at the edge that accepts the request.
    task automatic send_request(input logic [FW-1:0] b, input logic [FW-1:0] e,
                                input logic [FW-1:0] m);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        base <= b;
        exponent <= e;
        modulus <= m;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic send_random(input int count, input int max_exp_width);
        logic [FW-1:0] b;
        logic [FW-1:0] e;
        logic [FW-1:0] m;
        int pick;
        repeat (count)
        begin
            m = random_bits($urandom_range(1, FW));
            if (m == '0)
                m = FW'(1);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                b = m;
            else if (pick == 1)
                b = m - FW'(1);
            else if (pick < 6)
                b = random_bits(FW);
            else
                b = random_bits($urandom_range(0, FW));
            e = random_bits($urandom_range(0, max_exp_width));
            send_request(b, e, m);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        req_valid <= 1'b0;
        base <= '0;
        exponent <= '0;
        modulus <= '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold = 1'b0;
        quiet_cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests: zero exponent, modulus of one and zero, extreme operands.
        send_request('0, '0, FW'(1));
        send_request(FW'(5), '0, FW'(1));
        send_request(ALL_ONES, '0, ALL_ONES);
        send_request(FW'(5), '0, '0);
        send_request(FW'(5), FW'(3), '0);
        send_request('0, FW'(5), FW'(7));
        send_request(FW'(3), FW'(1), FW'(1));
        send_request(FW'(7), ALL_ONES, FW'(1));
        send_request(FW'(2), FW'(10), FW'(1000));
        send_request(ALL_ONES, ALL_ONES, ALL_ONES);
        send_request(ALL_ONES, ALL_ONES, ALL_ONES - FW'(1));
        send_request(ALL_ONES - FW'(1), FW'(2), ALL_ONES);
        send_request(FW'(12345), FW'(7), FW'(12345));
        send_request(FW'(12344), FW'(1) << (FW - 1), FW'(12345));
        send_request(FW'(2), FW'(62), ALL_ONES);
        send_request(ALL_ONES, FW'(1), FW'(2));
        send_request(FW'(1), ALL_ONES, ALL_ONES);
        send_request(FW'(3), MERSENNE_61 - FW'(1), MERSENNE_61);
        send_request('0, ALL_ONES, ALL_ONES);
        send_request({32'h5555_5555, 31'h5555_5555}, {32'h2AAA_AAAA, 31'h2AAA_AAAA},
                     {32'h7AAA_AAAA, 31'h2AAA_AAAA});
        wait_drained();

        // Results held back while requests keep coming, so the core backs up.
        long_hold = 1'b1;
        send_random(6, 4);
        wait_drained();

        send_random(28, FW);
        wait_drained();

        send_idle_pct = 75;
        send_random(28, FW);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 75;
        send_random(28, FW);
        wait_drained();

        send_idle_pct = 34;
        recv_stall_pct = 34;
        send_random(28, FW);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
